// ===== rtl/assert_macros.svh =====
// assertion macros used by the signed restoring divider
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/srdiv_pkg.sv =====
// shared constants and types for the signed restoring divider
// no dependencies; imported by srdiv_cell, signed_restoring_divider and the testbench
package srdiv_pkg;

   localparam int DATA_BYTES_DEFAULT = 8;
   localparam int PORT_WIDTH         = 64;

   // per-request control that travels down the cell row beside the data
   typedef struct packed {
      logic valid;
      logic neg_quo;
      logic neg_rem;
      logic div_zero;
   } srdiv_ctrl_type;

endpackage

// ===== rtl/srdiv_cell.sv =====
// one restoring division step: shift, trial subtract, restore, then register
// depends on srdiv_pkg
module srdiv_cell import srdiv_pkg::*; #(
   parameter int W = PORT_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  srdiv_ctrl_type ctrl_i,
   input  logic [W-1:0]   rem_i,
   input  logic [W-1:0]   aq_i,
   input  logic [W-1:0]   mag_b_i,
   output srdiv_ctrl_type ctrl_o,
   output logic [W-1:0]   rem_o,
   output logic [W-1:0]   aq_o,
   output logic [W-1:0]   mag_b_o
);

   srdiv_ctrl_type ctrl_ff;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   aq_ff, aq_in;
   logic [W-1:0]   mag_b_ff;
   logic [W:0]     rem_shift;
   logic [W+1:0]   diff;
   logic           q_bit;

   // partial remainder stays below the divisor, so the shifted value fits
   assign rem_shift = {rem_i, aq_i[W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, mag_b_i};
   assign q_bit     = ~diff[W+1];

   always_comb begin
      rem_in = q_bit ? diff[W-1:0] : rem_shift[W-1:0];
      aq_in  = {aq_i[W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      ctrl_ff.neg_quo  <= ctrl_i.neg_quo;
      ctrl_ff.neg_rem  <= ctrl_i.neg_rem;
      ctrl_ff.div_zero <= ctrl_i.div_zero;
      rem_ff           <= rem_in;
      aq_ff            <= aq_in;
      mag_b_ff         <= mag_b_i;
   end

   assign ctrl_o  = ctrl_ff;
   assign rem_o   = rem_ff;
   assign aq_o    = aq_ff;
   assign mag_b_o = mag_b_ff;

endmodule

// ===== rtl/signed_restoring_divider.sv =====
// signed restoring divider: operand prep, a row of division cells, sign fix-up
// depends on srdiv_pkg, srdiv_cell and assert_macros.svh
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is always low: the divider is fully pipelined and takes a new
//   request every cycle. Operands are the low W = 8*DATA_BYTES bits of
//   req_dividend and req_divisor, bit W-1 being the sign.
//   Each request yields one response, shown for exactly one cycle with
//   rsp_valid high; the receiver cannot hold it off, and none is needed
//   because nothing ever waits inside the block.
//   The pipeline has one prep stage that takes operand magnitudes,
//   one cell per quotient bit (W cells, one trial subtract each), and one
//   stage that restores the signs. Throughput is one request per cycle.
//   Quotient truncates toward zero, remainder takes the dividend's sign,
//   results are sign-extended to 64 bits. A zero divisor sets
//   rsp_div_by_zero with zero quotient and remainder.
//   Synchronous reset clears all valid flags; requests in flight are dropped.
`include "assert_macros.svh"
module signed_restoring_divider import srdiv_pkg::*; #(
   parameter int DATA_BYTES = DATA_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PORT_WIDTH-1:0] req_dividend,
   input  logic [PORT_WIDTH-1:0] req_divisor,
   output logic                  rsp_valid,
   output logic [PORT_WIDTH-1:0] rsp_quotient,
   output logic [PORT_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_div_by_zero
);

   localparam int W   = DATA_BYTES * 8;
   localparam int LAT = W + 2;

   logic           accept;
   logic [W-1:0]   a_w, b_w;
   srdiv_ctrl_type prep_ctrl_ff, prep_ctrl_in;
   logic [W-1:0]   mag_a_ff, mag_a_in;
   logic [W-1:0]   mag_b_ff, mag_b_in;

   srdiv_ctrl_type ctrl_chain [0:W];
   logic [W-1:0]   rem_chain  [0:W];
   logic [W-1:0]   aq_chain   [0:W];
   logic [W-1:0]   b_chain    [0:W];

   logic [W-1:0]   quo_fix, rem_fix;
   logic           valid_ff;
   logic [PORT_WIDTH-1:0] quo_ff, quo_in;
   logic [PORT_WIDTH-1:0] rem_ff, rem_in;
   logic           dbz_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // operand prep: magnitudes and sign decisions
   always_comb begin
      a_w = req_dividend[W-1:0];
      b_w = req_divisor[W-1:0];
      mag_a_in = a_w[W-1] ? (~a_w + W'(1)) : a_w;
      mag_b_in = b_w[W-1] ? (~b_w + W'(1)) : b_w;
      prep_ctrl_in.valid    = accept;
      prep_ctrl_in.neg_quo  = a_w[W-1] ^ b_w[W-1];
      prep_ctrl_in.neg_rem  = a_w[W-1];
      prep_ctrl_in.div_zero = (b_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ctrl_ff.valid <= 1'b0;
      end else begin
         prep_ctrl_ff.valid <= prep_ctrl_in.valid;
      end
      prep_ctrl_ff.neg_quo  <= prep_ctrl_in.neg_quo;
      prep_ctrl_ff.neg_rem  <= prep_ctrl_in.neg_rem;
      prep_ctrl_ff.div_zero <= prep_ctrl_in.div_zero;
      mag_a_ff              <= mag_a_in;
      mag_b_ff              <= mag_b_in;
   end

   assign ctrl_chain[0] = prep_ctrl_ff;
   assign rem_chain[0]  = '0;
   assign aq_chain[0]   = mag_a_ff;
   assign b_chain[0]    = mag_b_ff;

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < W; i++) begin : g_cell
      srdiv_cell #(.W(W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl_i  (ctrl_chain[i]),
         .rem_i   (rem_chain[i]),
         .aq_i    (aq_chain[i]),
         .mag_b_i (b_chain[i]),
         .ctrl_o  (ctrl_chain[i+1]),
         .rem_o   (rem_chain[i+1]),
         .aq_o    (aq_chain[i+1]),
         .mag_b_o (b_chain[i+1])
      );
   end

   // sign fix-up and divide-by-zero override
   always_comb begin
      quo_fix = ctrl_chain[W].neg_quo ? (~aq_chain[W] + W'(1)) : aq_chain[W];
      rem_fix = ctrl_chain[W].neg_rem ? (~rem_chain[W] + W'(1)) : rem_chain[W];
      if (ctrl_chain[W].div_zero) begin
         quo_in = '0;
         rem_in = '0;
      end else begin
         quo_in = PORT_WIDTH'(signed'(quo_fix));
         rem_in = PORT_WIDTH'(signed'(rem_fix));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl_chain[W].valid;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dbz_ff <= ctrl_chain[W].div_zero;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_quotient    = quo_ff;
   assign rsp_remainder   = rem_ff;
   assign rsp_div_by_zero = dbz_ff;

   // every response traces back to a request taken earlier
   `ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, $past(start, LAT), "response without request")
   `ASSERT_IMPL(a_dbz_zero, clock, reset, rsp_valid && rsp_div_by_zero, rsp_quotient == '0 && rsp_remainder == '0, "nonzero result on divide by zero")
   `ASSERT_IMPL(a_rem_sign, clock, reset, rsp_valid && rsp_remainder != '0, rsp_remainder[W-1] == $past(req_dividend[W-1], LAT), "remainder sign differs from dividend")
   `ASSERT_CLK(a_dbz_flag, clock, reset, !rsp_valid || (rsp_div_by_zero == ($past(req_divisor[W-1:0], LAT) == '0)), "divide-by-zero flag mismatch")

endmodule

// ===== tb/tb_signed_restoring_divider.sv =====
// self-checking testbench for the signed restoring divider
// depends on srdiv_pkg and signed_restoring_divider; predicts each response
// from the operands and compares it with the oldest outstanding request
module tb_signed_restoring_divider import srdiv_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_BYTES = DATA_BYTES_DEFAULT;
   localparam int W          = 8 * DATA_BYTES;
   localparam int LATENCY    = W + 2;

   localparam logic [PORT_WIDTH-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [PORT_WIDTH-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [PORT_WIDTH-1:0] quotient;
      logic [PORT_WIDTH-1:0] remainder;
      logic                  div_by_zero;
   } division_result_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic [PORT_WIDTH-1:0] req_dividend = '0;
   logic [PORT_WIDTH-1:0] req_divisor  = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [PORT_WIDTH-1:0] rsp_quotient;
   logic [PORT_WIDTH-1:0] rsp_remainder;
   logic                  rsp_div_by_zero;

   division_result_type pending_divisions[$];
   int                  error_count = 0;
   bit                  gaps_enabled = 1'b1;

   signed_restoring_divider #(.DATA_BYTES(DATA_BYTES)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_quotient    (rsp_quotient),
      .rsp_remainder   (rsp_remainder),
      .rsp_div_by_zero (rsp_div_by_zero)
   );

   always #10 clock = ~clock;

   // W-bit value sign-extended to the port width
   function automatic logic [PORT_WIDTH-1:0] sign_extend(input logic [PORT_WIDTH-1:0] v);
      logic [PORT_WIDTH-1:0] mask;
      mask = {PORT_WIDTH{1'b1}} >> (PORT_WIDTH - W);
      v = v & mask;
      if (v[W-1]) v = v | ~mask;
      return v;
   endfunction

   function automatic division_result_type compute_division(
         input logic [PORT_WIDTH-1:0] a_in,
         input logic [PORT_WIDTH-1:0] b_in);
      logic [PORT_WIDTH-1:0] mask, a, b, mag_a, mag_b, quo, rem;
      logic                  neg_a, neg_b;
      division_result_type   res;
      mask  = {PORT_WIDTH{1'b1}} >> (PORT_WIDTH - W);
      a     = a_in & mask;
      b     = b_in & mask;
      neg_a = a[W-1];
      neg_b = b[W-1];
      if (b == '0) begin
         res = '{quotient: '0, remainder: '0, div_by_zero: 1'b1};
         return res;
      end
      mag_a = neg_a ? ((~a + 64'd1) & mask) : a;
      mag_b = neg_b ? ((~b + 64'd1) & mask) : b;
      quo   = '0;
      rem   = '0;
      // shift in one dividend bit, trial subtract, keep on success
      for (int pos = W - 1; pos >= 0; pos--) begin
         rem = (rem << 1) | ((mag_a >> pos) & 64'd1);
         quo = quo << 1;
         if (rem >= mag_b) begin
            rem = rem - mag_b;
            quo = quo | 64'd1;
         end
      end
      quo = quo & mask;
      rem = rem & mask;
      if (neg_a != neg_b) quo = (~quo + 64'd1) & mask;
      if (neg_a) rem = (~rem + 64'd1) & mask;
      res = '{quotient: sign_extend(quo), remainder: sign_extend(rem), div_by_zero: 1'b0};
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_enabled || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PORT_WIDTH-1:0] random_operand();
      logic [PORT_WIDTH-1:0] v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
         1: begin
            v = 64'($urandom_range(0, 32));
            v = v - 64'd16;
         end
         2: begin
            // random magnitude length, random sign
            v = v >> $urandom_range(1, 63);
            if ($urandom_range(0, 1)) v = -v;
         end
         3: begin
            case ($urandom_range(0, 4))
               0: v = MOST_NEG;
               1: v = MOST_POS;
               2: v = '0;
               3: v = 64'd1;
               default: v = '1;
            endcase
         end
         4: begin
            v = 64'd1 << $urandom_range(0, 63);
            v = v + 64'($urandom_range(0, 2)) - 64'd1;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_division(input logic [PORT_WIDTH-1:0] dividend,
                                input logic [PORT_WIDTH-1:0] divisor);
      int gap;
      @(negedge clock);
      start        = 1'b1;
      req_dividend = dividend;
      req_divisor  = divisor;
      do @(posedge clock); while (busy);
      pending_divisions.insert(pending_divisions.size(),
                               compute_division(dividend, divisor));
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      division_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (pending_divisions.size() == 0) begin
            $error("response with no outstanding request: quotient %h remainder %h",
                   rsp_quotient, rsp_remainder);
            error_count++;
         end else begin
            exp_res = pending_divisions.pop_front();
            if (rsp_quotient !== exp_res.quotient) begin
               $error("quotient: expected %h, actual %h", exp_res.quotient, rsp_quotient);
               error_count++;
            end
            if (rsp_remainder !== exp_res.remainder) begin
               $error("remainder: expected %h, actual %h", exp_res.remainder, rsp_remainder);
               error_count++;
            end
            if (rsp_div_by_zero !== exp_res.div_by_zero) begin
               $error("div_by_zero: expected %b, actual %b",
                      exp_res.div_by_zero, rsp_div_by_zero);
               error_count++;
            end
         end
      end
   end

   // every pairing of the corner values, zero divisor and most negative by -1 among them
   task automatic test_operand_extremes();
      logic [PORT_WIDTH-1:0] corners [5];
      corners = '{64'd0, 64'd1, '1, MOST_POS, MOST_NEG};
      foreach (corners[i])
         foreach (corners[j])
            send_division(corners[i], corners[j]);
   endtask

   task automatic test_sign_combinations();
      send_division(64'sd7, 64'sd2);
      send_division(-64'sd7, 64'sd2);
      send_division(64'sd7, -64'sd2);
      send_division(-64'sd7, -64'sd2);
   endtask

   task automatic test_random_full_range(input int count);
      repeat (count) send_division({$urandom(), $urandom()}, {$urandom(), $urandom()});
   endtask

   task automatic test_random_back_to_back(input int count);
      gaps_enabled = 1'b0;
      repeat (count) send_division(random_operand(), random_operand());
      gaps_enabled = 1'b1;
   endtask

   task automatic test_random_shaped_operands(input int count);
      repeat (count) send_division(random_operand(), random_operand());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_operand_extremes();
      test_sign_combinations();
      test_random_full_range(400);
      test_random_back_to_back(200);
      test_random_shaped_operands(650);

      @(negedge clock);
      start = 1'b0;
      while (pending_divisions.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
